>>> design/paid_pkg.sv
// types and codes shared by the positional array and its cells
package paid_pkg;

	// operation codes of a request word
	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_DELETE = 2'd1,
		FN_SEARCH = 2'd2,
		FN_GET    = 2'd3
	} func_t;

	// status codes of a response word
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	localparam int DataW  = 32;
	localparam int PosW   = 4;
	localparam int CountW = 5;

	// request word
	typedef struct packed {
		func_t                    func;
		logic signed [DataW-1:0]  element;
		logic        [PosW-1:0]   pos;
	} req_t;

	// response word
	typedef struct packed {
		status_t                  status;
		logic signed [DataW-1:0]  read_value;
		logic                     found;
		logic        [PosW-1:0]   found_index;
		logic        [CountW-1:0] entry_count;
	} rsp_t;

	// what a cell does with its entry at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_t;

	// per-cell control: take marks a request word, the compare flag holds otherwise
	typedef struct packed {
		cell_op_t op;
		logic     cmp;
		logic     take;
	} cell_ctl_t;

endpackage

>>> design/paid_cell.sv
// one storage cell of the positional array: holds an entry, shifts and compares
module paid_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  paid_pkg::cell_ctl_t              ctl,
	input  logic signed [paid_pkg::DataW-1:0] element,
	input  logic signed [paid_pkg::DataW-1:0] left_data,
	input  logic signed [paid_pkg::DataW-1:0] right_data,
	output logic signed [paid_pkg::DataW-1:0] data,
	output logic                             match
);
	import paid_pkg::*;

	logic signed [DataW-1:0] data_q;
	logic                    match_q;

	// entry register, moved along the row on insert and delete
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_HOLD:       data_q <= data_q;
			CELL_LOAD:       data_q <= element;
			CELL_FROM_LEFT:  data_q <= left_data;
			CELL_FROM_RIGHT: data_q <= right_data;
			default:         data_q <= data_q;
		endcase
	end

	// compare result, taken with every request word and held until the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.take) begin
			match_q <= ctl.cmp && (data_q == element);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

>>> design/positional_array_insert_delete.sv
// top level of the positional array with insert, delete, search and get
// Holds up to DEPTH signed 32-bit entries in order, one per cell of a row of
// cells, plus a count. Insert, delete, search and get each take one request
// word and give one response word. A new word is taken every cycle while the
// response side keeps up. A taken request shifts the row and registers each
// cell's compare; the compare stage then picks the lowest matching cell (or
// reads the addressed cell) into the output register. A request is still
// taken while a response waits in the output register if the compare stage
// is empty; the compare stage then holds until that response is taken.
// The entries come out of reset undefined; only entries below the count are
// ever read.
module positional_array_insert_delete #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  paid_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output paid_pkg::rsp_t rsp
);
	import paid_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > PosW) ? CW : PosW;
	localparam int EW = (CW > CountW) ? CW : CountW;

	logic [CW-1:0] count_q;
	logic          acc;
	logic          s1_adv;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic          ins_ok;
	logic          del_ok;
	logic          get_ok;
	status_t       status_d;

	logic          valid_s1;
	func_t         func_s1;
	logic [PosW-1:0] pos_s1;
	status_t       status_s1;

	logic          rsp_valid_q;
	rsp_t          rsp_q;

	cell_ctl_t               cell_ctl  [DEPTH];
	logic signed [DataW-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]        match_vec;

	logic [DEPTH-1:0]        low_hit;
	logic [PosW-1:0]         hit_idx;
	logic signed [DataW-1:0] rd_data;
	logic [XW-1:0]           pos_s1_x;
	logic [EW-1:0]           cnt_e;

	// handshake
	assign s1_adv    = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !s1_adv;
	assign acc       = req_valid && !req_stall;

	// operation checks against the current count
	assign pos_x = XW'(req.pos);
	assign cnt_x = XW'(count_q);
	assign ins_ok = (req.func == FN_INSERT) && (count_q < CW'(DEPTH)) && (pos_x <= cnt_x);
	assign del_ok = (req.func == FN_DELETE) && (pos_x < cnt_x);
	assign get_ok = (req.func == FN_GET) && (pos_x < cnt_x);

	always_comb begin
		status_d = ST_OK;
		unique case (req.func)
			FN_INSERT: begin
				if (count_q >= CW'(DEPTH)) begin
					status_d = ST_FULL;
				end else if (!ins_ok) begin
					status_d = ST_RANGE;
				end
			end
			FN_DELETE: status_d = del_ok ? ST_OK : ST_RANGE;
			FN_SEARCH: status_d = ST_OK;
			FN_GET:    status_d = get_ok ? ST_OK : ST_RANGE;
			default:   status_d = ST_OK;
		endcase
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [XW-1:0] Idx = XW'(i);

		always_comb begin
			cell_ctl[i].op   = CELL_HOLD;
			cell_ctl[i].cmp  = acc && (req.func == FN_SEARCH) && (Idx < cnt_x);
			cell_ctl[i].take = acc;
			if (acc && ins_ok) begin
				if (Idx > pos_x) begin
					cell_ctl[i].op = CELL_FROM_LEFT;
				end else if (Idx == pos_x) begin
					cell_ctl[i].op = CELL_LOAD;
				end
			end else if (acc && del_ok && (Idx >= pos_x)) begin
				cell_ctl[i].op = CELL_FROM_RIGHT;
			end
		end

		paid_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl[i]),
			.element    (req.element),
			.left_data  ((i == 0) ? '0 : cell_data[(i == 0) ? 0 : i - 1]),
			.right_data ((i == DEPTH - 1) ? '0 : cell_data[(i == DEPTH - 1) ? i : i + 1]),
			.data       (cell_data[i]),
			.match      (match_vec[i])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc && ins_ok) begin
			count_q <= count_q + CW'(1);
		end else if (acc && del_ok) begin
			count_q <= count_q - CW'(1);
		end
	end

	// compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_s1   <= req.func;
			pos_s1    <= req.pos;
			status_s1 <= status_d;
		end
	end

	// lowest match: isolate the lowest set bit, then encode it
	assign low_hit = match_vec & (~match_vec + DEPTH'(1));

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			for (int b = 0; b < PosW; b++) begin
				if (((i >> b) & 1) == 1) begin
					hit_idx[b] = hit_idx[b] | low_hit[i];
				end
			end
		end
	end

	// read of the addressed cell
	assign pos_s1_x = XW'(pos_s1);

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (XW'(i) == pos_s1_x) begin
				rd_data = rd_data | cell_data[i];
			end
		end
	end

	assign cnt_e = EW'(count_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			rsp_q.status      <= status_s1;
			rsp_q.read_value  <= ((func_s1 == FN_GET) && (status_s1 == ST_OK)) ? rd_data : '0;
			rsp_q.found       <= (func_s1 == FN_SEARCH) && (|match_vec);
			rsp_q.found_index <= (func_s1 == FN_SEARCH) ? hit_idx : '0;
			rsp_q.entry_count <= cnt_e[CountW-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		acc && ins_ok |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the count");

	a_match_only_search: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (func_s1 != FN_SEARCH) |-> match_vec == '0)
		else $error("compare hit outside a search");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.found |-> rsp_q.status == ST_OK)
		else $error("found flag with error status");

endmodule

>>> tb/sv/positional_array_insert_delete_test.sv
// self-checking testbench for the positional array with insert, delete, search and get
module positional_array_insert_delete_test;
	import paid_pkg::*;

	localparam int Depth      = 16;
	localparam int ItemTarget = 1650;
	localparam int LongHold   = 60;
	localparam int IdleLimit  = 2000;
	localparam int DrainEvery = 350;
	localparam int SweepEvery = 400;

	// contents of the array as the block should hold them
	typedef struct packed {
		logic [Depth-1:0][DataW-1:0] slots;
		logic [CountW-1:0]           used;
	} array_image_t;

	// request word waiting to be sent, with its lead-in gap
	typedef struct packed {
		req_t       word;
		logic [3:0] gap;
		logic       drain;
	} pending_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	pending_t     pending_words[$];
	rsp_t         expected_rsps[$];
	array_image_t plan_array;
	array_image_t tracked_array;

	int unsigned planned;
	int unsigned burst_left;
	int unsigned words_taken;
	int unsigned results_seen;
	int unsigned mismatches;
	int unsigned idle_cycles;

	// driver bookkeeping
	bit          armed;
	int unsigned hold_left;
	logic        offer_valid;
	req_t        offer_word;
	pending_t    head_item;
	rsp_t        taken_rsp;

	// monitor bookkeeping
	int unsigned stall_left;
	int unsigned quiet_left;
	rsp_t        want_rsp;

	// operation tallies for the summary
	int unsigned n_insert_ok;
	int unsigned n_delete_ok;
	int unsigned n_get_ok;
	int unsigned n_search_hit;
	int unsigned n_search_miss;
	int unsigned n_full;
	int unsigned n_range;

	positional_array_insert_delete #(.DEPTH(Depth)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// applies one operation to an array image and gives the response it should produce
	function automatic rsp_t predict_array_op(input req_t w, inout array_image_t img);
		rsp_t        r;
		int unsigned n;
		int unsigned p;
		int unsigned i;
		bit          hit;
		r = '0;
		r.status = ST_OK;
		n = img.used;
		p = w.pos;
		hit = 1'b0;
		case (w.func)
			FN_INSERT: begin
				if (n >= Depth) begin
					r.status = ST_FULL;
				end else if (p > n) begin
					r.status = ST_RANGE;
				end else begin
					for (i = n; i > p; i--)
						img.slots[i] = img.slots[i-1];
					img.slots[p] = w.element;
					img.used = CountW'(n + 1);
				end
			end
			FN_DELETE: begin
				if (p >= n) begin
					r.status = ST_RANGE;
				end else begin
					for (i = p; i + 1 < n; i++)
						img.slots[i] = img.slots[i+1];
					img.used = CountW'(n - 1);
				end
			end
			FN_SEARCH: begin
				for (i = 0; i < n; i++) begin
					if (!hit && img.slots[i] == w.element) begin
						hit = 1'b1;
						r.found = 1'b1;
						r.found_index = i[PosW-1:0];
					end
				end
			end
			default: begin
				if (p >= n)
					r.status = ST_RANGE;
				else
					r.read_value = img.slots[p];
			end
		endcase
		r.entry_count = img.used;
		return r;
	endfunction

	// counts one mismatch and prints its line, for the first 100 mismatches
	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("error: result %0d: %s", results_seen, msg);
	endtask

	// value for an insert or search: often from a small pool so that duplicates occur
	function automatic logic signed [DataW-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return -32'sd1;
			3: return 32'sd0;
			4: return 32'sd1;
			5: return 32'sd5;
			default: return $urandom;
		endcase
	endfunction

	// queues one request word, tracking the planned array so sequences stay well formed
	task automatic push_item(input func_t f, input logic signed [DataW-1:0] e,
			input int unsigned p);
		pending_t it;
		it.word.func    = f;
		it.word.element = e;
		it.word.pos     = p[PosW-1:0];
		it.drain        = (planned > 0 && planned % DrainEvery == 0);
		if (burst_left > 0) begin
			burst_left--;
			it.gap = '0;
		end else begin
			if ($urandom_range(0, 99) < 3)
				burst_left = $urandom_range(20, 50);
			it.gap = 4'($urandom_range(0, 9));
		end
		void'(predict_array_op(it.word, plan_array));
		pending_words.push_back(it);
		planned++;
	endtask

	// search word for a value that is stored, when there is one
	task automatic push_search_stored();
		int unsigned k;
		if (plan_array.used == 0) begin
			push_item(FN_SEARCH, pick_value(), $urandom_range(0, 15));
		end else begin
			k = $urandom_range(0, plan_array.used - 1);
			push_item(FN_SEARCH, plan_array.slots[k], $urandom_range(0, 15));
		end
	endtask

	// fill to full, push against the full store, then empty again
	task automatic push_sweep();
		while (plan_array.used < Depth)
			push_item(FN_INSERT, pick_value(), $urandom_range(0, plan_array.used));
		push_item(FN_INSERT, pick_value(), 15);
		push_item(FN_INSERT, pick_value(), 0);
		push_item(FN_GET, $urandom, 15);
		push_item(FN_SEARCH, plan_array.slots[15], 0);
		push_search_stored();
		while (plan_array.used > 0) begin
			if ($urandom_range(0, 3) == 0)
				push_item(FN_GET, $urandom, $urandom_range(0, plan_array.used - 1));
			push_item(FN_DELETE, $urandom, $urandom_range(0, plan_array.used - 1));
		end
		push_item(FN_GET, $urandom, 0);
	endtask

	// one random word: mostly valid positions, drifting toward a moving fill level
	task automatic push_random(inout int unsigned fill_target);
		int unsigned r;
		int unsigned n;
		n = plan_array.used;
		if ($urandom_range(0, 99) < 5)
			fill_target = $urandom_range(0, Depth);
		r = $urandom_range(0, 99);
		if (r < 15) begin
			push_item(func_t'($urandom_range(0, 3)), pick_value(), $urandom_range(0, 15));
		end else if (r < 60) begin
			if (n < fill_target)
				push_item(FN_INSERT, pick_value(), $urandom_range(0, n));
			else if (n > fill_target)
				push_item(FN_DELETE, $urandom, $urandom_range(0, n - 1));
			else if (n > 0)
				push_item(FN_GET, $urandom, $urandom_range(0, n - 1));
			else
				push_item(FN_INSERT, pick_value(), 0);
		end else if (r < 80) begin
			if ($urandom_range(0, 9) < 6)
				push_search_stored();
			else
				push_item(FN_SEARCH, pick_value(), $urandom_range(0, 15));
		end else begin
			push_item(FN_GET, $urandom, (n > 0) ? $urandom_range(0, n - 1) : 0);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// stimulus plan, reset, and end of run
	initial begin
		int unsigned fill_target;
		int unsigned next_sweep;
		plan_array    = '0;
		tracked_array = '0;
		fill_target   = 8;

		// directed: empty store, edge positions, shifts, duplicates and extremes
		push_item(FN_GET, 32'sd0, 0);
		push_item(FN_DELETE, 32'sd0, 15);
		push_item(FN_SEARCH, 32'sh80000000, 0);
		push_item(FN_INSERT, 32'sd5, 1);
		push_item(FN_INSERT, 32'sh7fffffff, 0);
		push_item(FN_INSERT, 32'sh80000000, 1);
		push_item(FN_INSERT, -32'sd1, 0);
		push_item(FN_INSERT, 32'sh7fffffff, 2);
		push_item(FN_SEARCH, 32'sh7fffffff, 15);
		push_item(FN_SEARCH, 32'sh80000000, 0);
		push_item(FN_SEARCH, 32'sd0, 0);
		push_item(FN_GET, 32'sd0, 3);
		push_item(FN_GET, 32'sd0, 4);
		push_item(FN_DELETE, 32'sd0, 4);
		push_item(FN_DELETE, 32'sd0, 0);
		push_item(FN_DELETE, 32'sd0, 2);
		push_item(FN_GET, 32'sd0, 1);
		push_item(FN_INSERT, 32'sd0, 15);
		push_item(FN_SEARCH, -32'sd1, 0);
		push_item(FN_DELETE, 32'sd0, 1);
		push_item(FN_DELETE, 32'sd0, 0);
		push_item(FN_GET, 32'sh7fffffff, 0);

		// random: well-formed sequences with periodic full sweeps
		next_sweep = planned;
		while (planned < ItemTarget) begin
			if (planned >= next_sweep) begin
				push_sweep();
				next_sweep = planned + SweepEvery;
			end else begin
				push_random(fill_target);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (words_taken < planned || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d words: %0d inserts, %0d deletes, %0d gets, %0d/%0d search hits",
			words_taken, n_insert_ok, n_delete_ok, n_get_ok, n_search_hit,
			n_search_hit + n_search_miss);
		$display("rejected %0d inserts into a full store and %0d out-of-range positions",
			n_full, n_range);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// driver: send queued words, predicting each as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			armed      = 1'b0;
			hold_left  = 0;
		end else begin
			offer_valid = req_valid;
			offer_word  = req;
			if (req_valid && !req_stall) begin
				taken_rsp = predict_array_op(req, tracked_array);
				expected_rsps.push_back(taken_rsp);
				words_taken++;
				offer_valid = 1'b0;
				if (taken_rsp.status == ST_FULL)
					n_full++;
				else if (taken_rsp.status == ST_RANGE)
					n_range++;
				else if (req.func == FN_INSERT)
					n_insert_ok++;
				else if (req.func == FN_DELETE)
					n_delete_ok++;
				else if (req.func == FN_GET)
					n_get_ok++;
				else if (taken_rsp.found)
					n_search_hit++;
				else
					n_search_miss++;
			end
			if (!offer_valid && pending_words.size() > 0) begin
				if (!armed) begin
					hold_left = pending_words[0].gap;
					armed     = 1'b1;
				end
				if (hold_left > 0) begin
					hold_left--;
				end else if (!(pending_words[0].drain && expected_rsps.size() != 0)) begin
					head_item   = pending_words.pop_front();
					offer_word  = head_item.word;
					offer_valid = 1'b1;
					armed       = 1'b0;
				end
			end
			req_valid <= offer_valid;
			req       <= offer_word;
		end
	end

	// monitor: take response words with random stalls and compare with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
			quiet_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (expected_rsps.size() == 0) begin
					report_mismatch("response word with no request pending");
				end else begin
					want_rsp = expected_rsps.pop_front();
					if (rsp.status !== want_rsp.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp.status, want_rsp.status));
					if (rsp.read_value !== want_rsp.read_value)
						report_mismatch($sformatf("read_value %h, want %h",
							rsp.read_value, want_rsp.read_value));
					if (rsp.found !== want_rsp.found)
						report_mismatch($sformatf("found %b, want %b",
							rsp.found, want_rsp.found));
					if (rsp.found_index !== want_rsp.found_index)
						report_mismatch($sformatf("found_index %0d, want %0d",
							rsp.found_index, want_rsp.found_index));
					if (rsp.entry_count !== want_rsp.entry_count)
						report_mismatch($sformatf("entry_count %0d, want %0d",
							rsp.entry_count, want_rsp.entry_count));
				end
				// long hold-off so the block fills and stalls its input
				if (results_seen == 40 || results_seen == 1000) begin
					stall_left = LongHold;
				end else if (quiet_left > 0) begin
					quiet_left--;
					stall_left = 0;
				end else begin
					if ($urandom_range(0, 99) < 4)
						quiet_left = $urandom_range(20, 50);
					stall_left = $urandom_range(0, 9);
				end
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp_stall <= (stall_left != 0);
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
